// ===== design/assert_macros.svh =====
// Assertion helpers used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge while reset is released.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== design/xsfb_pkg.sv =====
package xsfb_pkg;

    localparam int SCREEN_WIDTH_DEF    = 64;
    localparam int SCREEN_HEIGHT_DEF   = 32;
    localparam int MAX_SPRITE_ROWS_DEF = 16;

    // Pixels carried by one sprite row.
    localparam int ROW_PIXELS = 8;

    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_DRAW  = 2'd1,
        ACT_READ  = 2'd2
    } t_action;

    // Table of v mod modulus for every 8-bit v, built by a running counter.
    function automatic logic [255:0][7:0] mod_table(input int modulus);
        logic [255:0][7:0] t;
        int                r;
        r = 0;
        for (int i = 0; i < 256; i++) begin
            t[i] = 8'(r);
            r    = r + 1;
            if (r == modulus) begin
                r = 0;
            end
        end
        return t;
    endfunction

endpackage

// ===== design/xsfb_row_mem.sv =====
module xsfb_row_mem #(
    parameter int SCREEN_WIDTH  = xsfb_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = xsfb_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_clr,
    input  logic                             i_rd_en,
    input  logic [$clog2(SCREEN_HEIGHT)-1:0] i_rd_addr,
    output logic [SCREEN_WIDTH-1:0]          o_rd_data,
    input  logic                             i_wr_en,
    input  logic [$clog2(SCREEN_HEIGHT)-1:0] i_wr_addr,
    input  logic [SCREEN_WIDTH-1:0]          i_wr_data
);

    logic [SCREEN_WIDTH-1:0]  mem [SCREEN_HEIGHT];
    logic [SCREEN_HEIGHT-1:0] r_row_valid;
    logic [SCREEN_HEIGHT-1:0] n_row_valid;
    logic [SCREEN_WIDTH-1:0]  r_rd_q;
    logic                     r_rd_valid;

    // A row that was never written since reset or the last clear reads as all off.
    always_comb begin
        n_row_valid = r_row_valid;
        if (i_clr) begin
            n_row_valid = '0;
        end else if (i_wr_en) begin
            n_row_valid[i_wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
        end else begin
            r_row_valid <= n_row_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_q     <= mem[i_rd_addr];
            r_rd_valid <= r_row_valid[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_q : '0;

endmodule

// ===== design/xsfb_lane.sv =====
module xsfb_lane #(
    parameter int SCREEN_WIDTH = xsfb_pkg::SCREEN_WIDTH_DEF,
    parameter int LANE         = 0
) (
    input  logic                            i_en,
    input  logic [$clog2(SCREEN_WIDTH)-1:0] i_xw,
    input  logic [SCREEN_WIDTH-1:0]         i_old_row,
    output logic [SCREEN_WIDTH-1:0]         o_mask,
    output logic                            o_hit
);

    localparam int COL_W = $clog2(SCREEN_WIDTH);

    logic [COL_W:0] col;
    logic           toggle;

    // Pixels past the right edge are clipped rather than wrapped.
    assign col    = {1'b0, i_xw} + (COL_W+1)'(LANE);
    assign toggle = i_en && (col < (COL_W+1)'(SCREEN_WIDTH));
    assign o_mask = toggle ? (SCREEN_WIDTH'(1) << col[COL_W-1:0]) : '0;
    assign o_hit  = toggle && i_old_row[col[COL_W-1:0]];

endmodule

// ===== design/xsfb_merge.sv =====
module xsfb_merge #(
    parameter int SCREEN_WIDTH = xsfb_pkg::SCREEN_WIDTH_DEF
) (
    input  logic [xsfb_pkg::ROW_PIXELS-1:0][SCREEN_WIDTH-1:0] i_masks,
    input  logic [xsfb_pkg::ROW_PIXELS-1:0]                   i_hits,
    input  logic [SCREEN_WIDTH-1:0]                           i_old_row,
    input  logic                                              i_is_draw,
    input  logic                                              i_first,
    input  logic                                              i_flag,
    output logic [SCREEN_WIDTH-1:0]                           o_new_row,
    output logic                                              o_flag
);

    logic [SCREEN_WIDTH-1:0] mask;

    always_comb begin
        mask = '0;
        for (int i = 0; i < xsfb_pkg::ROW_PIXELS; i++) begin
            mask = mask | i_masks[i];
        end
    end

    assign o_new_row = i_old_row ^ mask;

    // A pixel that was on and is toggled turns off, which is a collision.
    always_comb begin
        o_flag = i_flag;
        if (i_is_draw) begin
            o_flag = (i_flag && !i_first) || (|i_hits);
        end
    end

endmodule

// ===== design/xor_sprite_framebuffer.sv =====
// One-bit framebuffer of SCREEN_WIDTH by SCREEN_HEIGHT pixels with XOR sprite drawing.
// Commands: raise start with the action and its operands; a command is taken on
// a rising edge where start is high and busy is low. Actions are clear screen,
// draw one 8-pixel sprite row, and read one pixel.
// Every command gives exactly one result: o_done is high for one cycle with
// o_collision, o_pixel_on and o_sprite_done. busy is set at the edge that takes
// the command and o_done is registered from it; busy is high for the one cycle between.
// A new command cannot be taken while busy is high. That limit is set by the
// read-modify-write of one framebuffer row: the row is read at the edge that
// takes the command and written back in the cycle after, with eight pixel lanes
// working on it in parallel.
// A clear takes effect at once through one valid bit per row, so a clear is
// no slower than any other command.
// Reset (i_rst_n low, synchronous) turns every pixel off, clears the collision
// flag and drops busy and o_done. The receiver cannot stall: each result is
// signalled by o_done for exactly one cycle.
`include "assert_macros.svh"

module xor_sprite_framebuffer #(
    parameter int SCREEN_WIDTH    = xsfb_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT   = xsfb_pkg::SCREEN_HEIGHT_DEF,
    parameter int MAX_SPRITE_ROWS = xsfb_pkg::MAX_SPRITE_ROWS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_action,
    input  logic [7:0] i_x_pos,
    input  logic [7:0] i_y_pos,
    input  logic [3:0] i_row_offset,
    input  logic [7:0] i_sprite_row,
    input  logic       i_last_row,
    output logic       o_done,
    output logic       o_collision,
    output logic       o_pixel_on,
    output logic       o_sprite_done
);

    localparam int COL_W = $clog2(SCREEN_WIDTH);
    localparam int ROW_W = $clog2(SCREEN_HEIGHT);
    localparam int NLANE = xsfb_pkg::ROW_PIXELS;
    localparam logic [255:0][7:0] X_MOD = xsfb_pkg::mod_table(SCREEN_WIDTH);
    localparam logic [255:0][7:0] Y_MOD = xsfb_pkg::mod_table(SCREEN_HEIGHT);

    logic                   accept;
    xsfb_pkg::t_action      in_action;
    logic [7:0]             xw;
    logic [7:0]             yw;
    logic [8:0]             row_sum;
    logic                   draw_ok;
    logic [ROW_W-1:0]       rd_addr;

    logic                   r_busy;
    xsfb_pkg::t_action      r_action;
    logic [COL_W-1:0]       r_xw;
    logic [ROW_W-1:0]       r_row;
    logic                   r_draw_ok;
    logic [NLANE-1:0]       r_bits;
    logic                   r_last;
    logic                   r_first;
    logic                   r_flag;
    logic                   n_flag;

    logic                   r_done;
    logic                   r_collision;
    logic                   r_pixel_on;
    logic                   r_sprite_done;

    logic                   is_draw;
    logic                   is_read;
    logic                   wr_en;
    logic [SCREEN_WIDTH-1:0] old_row;
    logic [SCREEN_WIDTH-1:0] new_row;
    logic [NLANE-1:0][SCREEN_WIDTH-1:0] lane_mask;
    logic [NLANE-1:0]       lane_hit;

    assign accept    = start && !r_busy;
    assign in_action = xsfb_pkg::t_action'(i_action);
    assign xw        = X_MOD[i_x_pos];
    assign yw        = Y_MOD[i_y_pos];
    assign row_sum   = {1'b0, yw} + 9'(i_row_offset);
    assign draw_ok   = ({1'b0, i_row_offset} < 5'(MAX_SPRITE_ROWS))
                    && (row_sum < 9'(SCREEN_HEIGHT));
    assign rd_addr   = (in_action == xsfb_pkg::ACT_READ) ? yw[ROW_W-1:0]
                                                          : row_sum[ROW_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action  <= in_action;
            r_xw      <= xw[COL_W-1:0];
            r_row     <= rd_addr;
            r_draw_ok <= draw_ok;
            r_bits    <= i_sprite_row;
            r_last    <= i_last_row;
            r_first   <= (i_row_offset == 4'd0);
        end
    end

    xsfb_row_mem #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clr     (accept && (in_action == xsfb_pkg::ACT_CLEAR)),
        .i_rd_en   (accept),
        .i_rd_addr (rd_addr),
        .o_rd_data (old_row),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_row),
        .i_wr_data (new_row)
    );

    assign is_draw = r_busy && (r_action == xsfb_pkg::ACT_DRAW);
    assign is_read = r_busy && (r_action == xsfb_pkg::ACT_READ);
    assign wr_en   = is_draw && r_draw_ok;

    // Bit 7 of the sprite row is the leftmost pixel and goes to lane 0.
    for (genvar g = 0; g < NLANE; g++) begin : g_lane
        xsfb_lane #(
            .SCREEN_WIDTH (SCREEN_WIDTH),
            .LANE         (g)
        ) u_lane (
            .i_en      (wr_en && r_bits[NLANE-1-g]),
            .i_xw      (r_xw),
            .i_old_row (old_row),
            .o_mask    (lane_mask[g]),
            .o_hit     (lane_hit[g])
        );
    end

    xsfb_merge #(
        .SCREEN_WIDTH (SCREEN_WIDTH)
    ) u_merge (
        .i_masks   (lane_mask),
        .i_hits    (lane_hit),
        .i_old_row (old_row),
        .i_is_draw (is_draw),
        .i_first   (r_first),
        .i_flag    (r_flag),
        .o_new_row (new_row),
        .o_flag    (n_flag)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_flag <= n_flag;
            r_done <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_collision   <= is_draw && n_flag;
            r_pixel_on    <= is_read && old_row[r_xw];
            r_sprite_done <= is_draw && r_last;
        end
    end

    assign busy          = r_busy;
    assign o_done        = r_done;
    assign o_collision   = r_collision;
    assign o_pixel_on    = r_pixel_on;
    assign o_sprite_done = r_sprite_done;

    `ASSERT_CLK(a_take_sets_busy, (start && !busy) |=> busy, "taken command did not raise busy")
    `ASSERT_CLK(a_busy_gives_done, busy |=> (o_done && !busy), "busy cycle not followed by a result")
    `ASSERT_CLK(a_read_fields, (o_done && o_pixel_on) |-> (!o_collision && !o_sprite_done),
        "read result carries draw fields")
    `ASSERT_ALWAYS(a_done_one_cycle, o_done |=> !o_done, "result strobe held for two cycles")

endmodule
